// ===== src/sine_cosine_poly_approx_macros.svh =====
// Assertion helpers for the sine/cosine unit
`ifndef SINE_COSINE_POLY_APPROX_MACROS_SVH
`define SINE_COSINE_POLY_APPROX_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked property, quiet while reset is asserted
`define SCPA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also watched during reset
`define SCPA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCPA_ASSERT(label, clk, rst_n, prop, msg)
`define SCPA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== src/scpa_pkg.sv =====
package scpa_pkg;

  // single-precision constants
  localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] FP_DEF_NAN  = 32'hFFC0_0000;
  localparam logic [31:0] FP_PI_HALF  = 32'h3FC9_0FDB;
  localparam logic [31:0] FP_INV_PI   = 32'h3EA2_F983;
  localparam logic [31:0] FP_HALF     = 32'h3F00_0000;
  localparam logic [31:0] FP_PI       = 32'h4049_0FDB;
  // 2^31: turn counts at or above this cannot be reduced
  localparam logic [31:0] FP_TURN_LIM = 32'h4F00_0000;

  // coefficient register reset values
  localparam logic [31:0] COEF_CUBIC_RST   = 32'hBE2A_AAAB;
  localparam logic [31:0] COEF_QUINTIC_RST = 32'h3C08_8889;
  localparam logic [31:0] COEF_SEPTIC_RST  = 32'hB950_0D01;
  localparam logic [31:0] COEF_NONIC_RST   = 32'h3638_EF1D;

  // register indexes
  localparam logic [1:0] REG_CUBIC   = 2'd0;
  localparam logic [1:0] REG_QUINTIC = 2'd1;
  localparam logic [1:0] REG_SEPTIC  = 2'd2;
  localparam logic [1:0] REG_NONIC   = 2'd3;

  // NaN with the quiet bit forced
  function automatic logic [31:0] fp_quiet(input logic [31:0] x);
    return x | 32'h0040_0000;
  endfunction

  function automatic logic fp_is_nan(input logic [31:0] x);
    return (&x[30:23]) && (|x[22:0]);
  endfunction

  // leading zeros of a 24-bit significand
  function automatic logic [4:0] lzc24(input logic [23:0] x);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  // leading zeros of a 27-bit sum
  function automatic logic [4:0] lzc27(input logic [26:0] x);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (x[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

endpackage

// ===== src/scpa_fadd.sv =====
// Three-stage single-precision adder, round to nearest even, subnormals kept.
// sub_i negates b after the NaN check.
module scpa_fadd (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic        sub_i,
  output logic [31:0] y_o
);
  import scpa_pkg::*;

  // stage 1: unpack, order by magnitude, align
  logic        bs;
  logic [7:0]  ea, eb, eh, el;
  logic [23:0] ma, mb, mh, ml;
  logic        sh_sign, swap;
  logic [7:0]  d;
  logic [26:0] sm_full, sm_al;
  logic        spec_d;
  logic [31:0] spec_val_d;

  always_comb begin
    bs = b_i[31] ^ sub_i;
    ea = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb = {b_i[30:23] != 8'd0, b_i[22:0]};
    swap = {eb, mb} > {ea, ma};
    eh = swap ? eb : ea;
    el = swap ? ea : eb;
    mh = swap ? mb : ma;
    ml = swap ? ma : mb;
    sh_sign = swap ? bs : a_i[31];
    d = eh - el;
    sm_full = {ml, 3'b000};
    if (d > 8'd26) begin
      sm_al = {26'd0, |sm_full};
    end else begin
      sm_al = (sm_full >> d[4:0]) |
              {26'd0, |(sm_full & ~({27{1'b1}} << d[4:0]))};
    end
    // operands that bypass the arithmetic
    spec_d = 1'b1;
    priority if (fp_is_nan(a_i)) begin
      spec_val_d = fp_quiet(a_i);
    end else if (fp_is_nan(b_i)) begin
      spec_val_d = fp_quiet(b_i);
    end else if ((&a_i[30:23]) && (&b_i[30:23]) && (a_i[31] != bs)) begin
      spec_val_d = FP_DEF_NAN;
    end else if (&a_i[30:23]) begin
      spec_val_d = a_i;
    end else if (&b_i[30:23]) begin
      spec_val_d = {bs, b_i[30:0]};
    end else begin
      spec_d = 1'b0;
      spec_val_d = a_i;
    end
  end

  logic [26:0] s1_big_q, s1_sm_q;
  logic [7:0]  s1_e_q;
  logic        s1_sign_q, s1_sub_q, s1_spec_q;
  logic [31:0] s1_spec_val_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_big_q      <= {mh, 3'b000};
      s1_sm_q       <= sm_al;
      s1_e_q        <= eh;
      s1_sign_q     <= sh_sign;
      s1_sub_q      <= a_i[31] ^ bs;
      s1_spec_q     <= spec_d;
      s1_spec_val_q <= spec_val_d;
    end
  end

  // stage 2: add or subtract, count leading zeros
  logic [27:0] sum_d;
  assign sum_d = s1_sub_q ? ({1'b0, s1_big_q} - {1'b0, s1_sm_q})
                          : ({1'b0, s1_big_q} + {1'b0, s1_sm_q});

  logic [27:0] s2_sum_q;
  logic [4:0]  s2_lz_q;
  logic [7:0]  s2_e_q;
  logic        s2_sign_q, s2_sub_q, s2_spec_q;
  logic [31:0] s2_spec_val_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sum_q      <= sum_d;
      s2_lz_q       <= lzc27(sum_d[26:0]);
      s2_e_q        <= s1_e_q;
      s2_sign_q     <= s1_sign_q;
      s2_sub_q      <= s1_sub_q;
      s2_spec_q     <= s1_spec_q;
      s2_spec_val_q <= s1_spec_val_q;
    end
  end

  // stage 3: normalise and round
  logic [26:0] nrm;
  logic [8:0]  e_n;
  logic [7:0]  max_sh, shamt;
  logic [7:0]  field;
  logic        g, st, rup, sign_r;
  logic [30:0] rnd;
  logic [31:0] y_d;

  always_comb begin
    max_sh = s2_e_q - 8'd1;
    shamt = 8'd0;
    if (s2_sum_q[27]) begin
      nrm = {s2_sum_q[27:2], s2_sum_q[1] | s2_sum_q[0]};
      e_n = {1'b0, s2_e_q} + 9'd1;
    end else begin
      shamt = ({3'b000, s2_lz_q} < max_sh) ? {3'b000, s2_lz_q} : max_sh;
      nrm = s2_sum_q[26:0] << shamt[4:0];
      e_n = {1'b0, s2_e_q} - {1'b0, shamt};
    end
    field = nrm[26] ? e_n[7:0] : 8'd0;
    g = nrm[2];
    st = nrm[1] | nrm[0];
    rup = g & (st | nrm[3]);
    rnd = {field, nrm[25:3]} + {30'd0, rup};
    sign_r = (s2_sum_q == 28'd0 && s2_sub_q) ? 1'b0 : s2_sign_q;
    if (s2_spec_q) begin
      y_d = s2_spec_val_q;
    end else if (e_n >= 9'd255) begin
      y_d = {sign_r, 8'hFF, 23'd0};
    end else begin
      y_d = {sign_r, rnd};
    end
  end

  logic [31:0] y_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= y_d;
    end
  end
  assign y_o = y_q;

endmodule

// ===== src/scpa_fmul.sv =====
// Three-stage single-precision multiplier, round to nearest even,
// subnormals kept.
module scpa_fmul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);
  import scpa_pkg::*;

  // stage 1: unpack and normalise subnormal significands
  logic [23:0] ma, mb;
  logic [4:0]  lza, lzb;
  logic signed [10:0] exa, exb;
  logic        za, zb, ia, ib, sgn;
  logic        spec_d;
  logic [31:0] spec_val_d;

  always_comb begin
    ma = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb = {b_i[30:23] != 8'd0, b_i[22:0]};
    lza = lzc24(ma);
    lzb = lzc24(mb);
    exa = $signed({3'b000, (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23]})
          - $signed({6'd0, lza});
    exb = $signed({3'b000, (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23]})
          - $signed({6'd0, lzb});
    za = (a_i[30:0] == 31'd0);
    zb = (b_i[30:0] == 31'd0);
    ia = (&a_i[30:23]) && (a_i[22:0] == 23'd0);
    ib = (&b_i[30:23]) && (b_i[22:0] == 23'd0);
    sgn = a_i[31] ^ b_i[31];
    spec_d = 1'b1;
    priority if (fp_is_nan(a_i)) begin
      spec_val_d = fp_quiet(a_i);
    end else if (fp_is_nan(b_i)) begin
      spec_val_d = fp_quiet(b_i);
    end else if ((ia && zb) || (ib && za)) begin
      spec_val_d = FP_DEF_NAN;
    end else if (ia || ib) begin
      spec_val_d = {sgn, 8'hFF, 23'd0};
    end else if (za || zb) begin
      spec_val_d = {sgn, 31'd0};
    end else begin
      spec_d = 1'b0;
      spec_val_d = a_i;
    end
  end

  logic [23:0] s1_ma_q, s1_mb_q;
  logic signed [10:0] s1_e_q;
  logic        s1_sign_q, s1_spec_q;
  logic [31:0] s1_spec_val_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_ma_q       <= ma << lza;
      s1_mb_q       <= mb << lzb;
      s1_e_q        <= exa + exb - 11'sd126;
      s1_sign_q     <= sgn;
      s1_spec_q     <= spec_d;
      s1_spec_val_q <= spec_val_d;
    end
  end

  // stage 2: significand product
  logic [47:0] s2_prod_q;
  logic signed [10:0] s2_e_q;
  logic        s2_sign_q, s2_spec_q;
  logic [31:0] s2_spec_val_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_prod_q     <= s1_ma_q * s1_mb_q;
      s2_e_q        <= s1_e_q;
      s2_sign_q     <= s1_sign_q;
      s2_spec_q     <= s1_spec_q;
      s2_spec_val_q <= s1_spec_val_q;
    end
  end

  // stage 3: normalise, denormalise on underflow, round
  logic [47:0] p, ps;
  logic signed [10:0] er;
  logic [5:0]  sh;
  logic [7:0]  field;
  logic [22:0] frac;
  logic        g, st, rup;
  logic [30:0] rnd;
  logic [31:0] y_d;

  always_comb begin
    if (s2_prod_q[47]) begin
      p = s2_prod_q;
      er = s2_e_q;
    end else begin
      p = s2_prod_q << 1;
      er = s2_e_q - 11'sd1;
    end
    sh = 6'd0;
    ps = p;
    if (er >= 11'sd1) begin
      field = er[7:0];
      frac = p[46:24];
      g = p[23];
      st = |p[22:0];
    end else begin
      sh = (er < -11'sd46) ? 6'd48 : 6'(11'sd1 - er);
      ps = p >> sh;
      field = 8'd0;
      frac = ps[46:24];
      g = ps[23];
      st = (|ps[22:0]) | (|(p & ~({48{1'b1}} << sh)));
    end
    rup = g & (st | frac[0]);
    rnd = {field, frac} + {30'd0, rup};
    if (s2_spec_q) begin
      y_d = s2_spec_val_q;
    end else if (er > 11'sd254) begin
      y_d = {s2_sign_q, 8'hFF, 23'd0};
    end else begin
      y_d = {s2_sign_q, rnd};
    end
  end

  logic [31:0] y_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= y_d;
    end
  end
  assign y_o = y_q;

endmodule

// ===== src/sine_cosine_poly_approx.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o   req_type_i, angle_bits_i
// out       output     out_valid_o/out_stall_i result_bits_o, range_error_o
// config    APB        psel/penable/pwrite     paddr, pwdata, prdata
//
// One angle accepted per cycle while in_stall_o is low.
// The datapath is a chain of fifteen float add/multiply units.
// Reset clears valid bits and loads the default coefficients.
// A stalled output parks one result in a skid register; in_stall_o rises
// only once that register holds a result.
`include "sine_cosine_poly_approx_macros.svh"

module sine_cosine_poly_approx (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] angle_bits_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_bits_o,
  output logic        range_error_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scpa_pkg::*;

  localparam int unsigned Depth = 48;

  // coefficient registers
  logic [31:0] cubic_q, quintic_q, septic_q, nonic_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cubic_q   <= COEF_CUBIC_RST;
      quintic_q <= COEF_QUINTIC_RST;
      septic_q  <= COEF_SEPTIC_RST;
      nonic_q   <= COEF_NONIC_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_CUBIC:   cubic_q   <= pwdata;
        REG_QUINTIC: quintic_q <= pwdata;
        REG_SEPTIC:  septic_q  <= pwdata;
        REG_NONIC:   nonic_q   <= pwdata;
        default:     cubic_q   <= cubic_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CUBIC:   prdata = cubic_q;
      REG_QUINTIC: prdata = quintic_q;
      REG_SEPTIC:  prdata = septic_q;
      REG_NONIC:   prdata = nonic_q;
      default:     prdata = 32'd0;
    endcase
  end

  // global advance: the pipeline moves while the skid register is free
  logic skid_v_q;
  logic en;
  assign en = ~skid_v_q;
  assign in_stall_o = skid_v_q;

  // valid bits, one per stage
  logic vld_q [Depth+1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Depth; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i <= Depth; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // t0: input register
  logic [31:0] a0_q;
  logic        req0_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q   <= angle_bits_i;
      req0_q <= req_type_i;
    end
  end

  // t0..t3: cosine offset
  logic [31:0] a_dl_q [3];
  logic        req_dl_q [3];
  logic [31:0] sum3;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_dl_q[0]   <= a0_q;
      req_dl_q[0] <= req0_q;
      for (int i = 1; i < 3; i++) begin
        a_dl_q[i]   <= a_dl_q[i-1];
        req_dl_q[i] <= req_dl_q[i-1];
      end
    end
  end

  scpa_fadd u_add_cos (
    .clk_i(clk_i), .en_i(en), .a_i(a0_q), .b_i(FP_PI_HALF), .sub_i(1'b0), .y_o(sum3)
  );

  // t4: magnitude, sign, non-finite check
  logic [31:0] a3, mag4_q;
  logic        neg4_q, err4_q;
  assign a3 = req_dl_q[2] ? sum3 : a_dl_q[2];
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag4_q <= {1'b0, a3[30:0]};
      neg4_q <= a3[31] & (|a3[30:0]);
      err4_q <= &a3[30:23];
    end
  end

  // t4..t10: turn count estimate
  logic [31:0] m7, tf10;
  scpa_fmul u_mul_invpi (
    .clk_i(clk_i), .en_i(en), .a_i(mag4_q), .b_i(FP_INV_PI), .y_o(m7)
  );
  scpa_fadd u_add_half (
    .clk_i(clk_i), .en_i(en), .a_i(m7), .b_i(FP_HALF), .sub_i(1'b0), .y_o(tf10)
  );

  logic [31:0] mag_dl_q [10];
  logic        neg_dl_q [6];
  logic        err_dl_q [6];
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_dl_q[0] <= mag4_q;
      for (int i = 1; i < 10; i++) mag_dl_q[i] <= mag_dl_q[i-1];
      neg_dl_q[0] <= neg4_q;
      err_dl_q[0] <= err4_q;
      for (int i = 1; i < 6; i++) begin
        neg_dl_q[i] <= neg_dl_q[i-1];
        err_dl_q[i] <= err_dl_q[i-1];
      end
    end
  end

  // t11: truncate turn count, take its parity
  logic [7:0]  k;
  logic [4:0]  fbits;
  logic [31:0] turns;
  logic [23:0] sig;
  logic        odd;
  always_comb begin
    k = tf10[30:23] - 8'd127;
    sig = {1'b1, tf10[22:0]};
    fbits = 5'd0;
    turns = tf10;
    odd = 1'b0;
    if (tf10[30:23] < 8'd127) begin
      turns = 32'd0;
    end else if (k <= 8'd23) begin
      fbits = 5'(8'd23 - k);
      turns = tf10 & ({32{1'b1}} << fbits);
      odd = sig[fbits];
    end
  end

  logic [31:0] turns11_q;
  logic        sgn11_q, err11_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      turns11_q <= turns;
      sgn11_q   <= neg_dl_q[5] ^ odd;
      err11_q   <= err_dl_q[5] | (tf10 >= FP_TURN_LIM);
    end
  end

  // t11..t20: reduced angle and its square
  logic [31:0] p14, red17, sq20;
  scpa_fmul u_mul_pi (
    .clk_i(clk_i), .en_i(en), .a_i(turns11_q), .b_i(FP_PI), .y_o(p14)
  );
  scpa_fadd u_sub_red (
    .clk_i(clk_i), .en_i(en), .a_i(mag_dl_q[9]), .b_i(p14), .sub_i(1'b1), .y_o(red17)
  );
  scpa_fmul u_mul_sq (
    .clk_i(clk_i), .en_i(en), .a_i(red17), .b_i(red17), .y_o(sq20)
  );

  logic [31:0] red_dl_q [27];
  logic [31:0] sq_dl_q [18];
  always_ff @(posedge clk_i) begin
    if (en) begin
      red_dl_q[0] <= red17;
      for (int i = 1; i < 27; i++) red_dl_q[i] <= red_dl_q[i-1];
      sq_dl_q[0] <= sq20;
      for (int i = 1; i < 18; i++) sq_dl_q[i] <= sq_dl_q[i-1];
    end
  end

  // t20..t41: Horner evaluation in the square
  logic [31:0] x23, x26, x29, x32, x35, x38, poly41, rp44, x47;
  scpa_fmul u_mul_h0 (
    .clk_i(clk_i), .en_i(en), .a_i(nonic_q), .b_i(sq20), .y_o(x23)
  );
  scpa_fadd u_add_h0 (
    .clk_i(clk_i), .en_i(en), .a_i(x23), .b_i(septic_q), .sub_i(1'b0), .y_o(x26)
  );
  scpa_fmul u_mul_h1 (
    .clk_i(clk_i), .en_i(en), .a_i(x26), .b_i(sq_dl_q[5]), .y_o(x29)
  );
  scpa_fadd u_add_h1 (
    .clk_i(clk_i), .en_i(en), .a_i(x29), .b_i(quintic_q), .sub_i(1'b0), .y_o(x32)
  );
  scpa_fmul u_mul_h2 (
    .clk_i(clk_i), .en_i(en), .a_i(x32), .b_i(sq_dl_q[11]), .y_o(x35)
  );
  scpa_fadd u_add_h2 (
    .clk_i(clk_i), .en_i(en), .a_i(x35), .b_i(cubic_q), .sub_i(1'b0), .y_o(x38)
  );
  scpa_fmul u_mul_h3 (
    .clk_i(clk_i), .en_i(en), .a_i(x38), .b_i(sq_dl_q[17]), .y_o(poly41)
  );

  // t41..t47: red + red * poly
  scpa_fmul u_mul_rp (
    .clk_i(clk_i), .en_i(en), .a_i(red_dl_q[23]), .b_i(poly41), .y_o(rp44)
  );
  scpa_fadd u_add_rp (
    .clk_i(clk_i), .en_i(en), .a_i(rp44), .b_i(red_dl_q[26]), .sub_i(1'b0), .y_o(x47)
  );

  logic sgn_dl_q [36];
  logic err_tl_q [36];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sgn_dl_q[0] <= sgn11_q;
      err_tl_q[0] <= err11_q;
      for (int i = 1; i < 36; i++) begin
        sgn_dl_q[i] <= sgn_dl_q[i-1];
        err_tl_q[i] <= err_tl_q[i-1];
      end
    end
  end

  // t48: apply sign, force quiet NaN on range errors
  logic [31:0] res48_q;
  logic        rerr48_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      rerr48_q <= err_tl_q[35];
      if (err_tl_q[35]) begin
        res48_q <= FP_QNAN;
      end else if (fp_is_nan(x47)) begin
        res48_q <= x47;
      end else begin
        res48_q <= {x47[31] ^ sgn_dl_q[35], x47[30:0]};
      end
    end
  end

  // output register and skid register
  logic        out_valid_q;
  logic [31:0] out_res_q, skid_res_q;
  logic        out_err_q, skid_err_q;
  logic        out_free;
  assign out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_v_q    <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_valid_q <= 1'b1;
        skid_v_q    <= 1'b0;
      end else begin
        out_valid_q <= vld_q[Depth];
      end
    end else if (!skid_v_q && vld_q[Depth]) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_res_q <= skid_res_q;
        out_err_q <= skid_err_q;
      end else begin
        out_res_q <= res48_q;
        out_err_q <= rerr48_q;
      end
    end else if (!skid_v_q) begin
      skid_res_q <= res48_q;
      skid_err_q <= rerr48_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_bits_o = out_res_q;
  assign range_error_o = out_err_q;

  // checks
  `SCPA_ASSERT(a_skid_fill, clk_i, rst_ni, $rose(skid_v_q) |-> $past(out_valid_q && out_stall_i), "skid filled without a stalled output")
  `SCPA_ASSERT(a_skid_needs_out, clk_i, rst_ni, skid_v_q |-> out_valid_q, "skid holds a result while output is empty")
  `SCPA_ASSERT(a_skid_drain, clk_i, rst_ni, skid_v_q && !out_stall_i |=> !skid_v_q, "skid did not drain")
  `SCPA_ASSERT(a_err_nan, clk_i, rst_ni, out_valid_q && out_err_q |-> out_res_q == FP_QNAN, "range error without quiet NaN")
  `SCPA_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o && !in_stall_o, "outputs active in reset")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import scpa_pkg::*;

  localparam int          WDOG_LIMIT = 4000;
  localparam int          DRAIN_WAIT = 60;
  localparam int          RAND_ITEMS = 305;
  localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
  localparam logic [31:0] FP_NEG_ONE = 32'hBF80_0000;
  localparam logic [31:0] FP_FOUR    = 32'h4080_0000;
  localparam logic [31:0] FP_PINF    = 32'h7F80_0000;
  localparam logic [31:0] FP_NINF    = 32'hFF80_0000;
  localparam logic [31:0] FP_MAXF    = 32'h7F7F_FFFF;

  typedef struct packed {
    logic [31:0] rbits;
    logic        rerr;
  } trig_res_t;

  // directed row: typed rows carry their expected result
  typedef struct packed {
    logic        req;
    logic [31:0] ang;
    logic        typed;
    logic [31:0] rbits;
    logic        rerr;
  } row_t;

  logic        clk_i;
  logic        rst_ni = 1'b1;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        req_type_i;
  logic [31:0] angle_bits_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] result_bits_o;
  logic        range_error_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sine_cosine_poly_approx DUT (.*);

  // coefficient copy used by the predictor
  logic [31:0] coef_c, coef_q, coef_s, coef_n;
  trig_res_t   trig_q[$];
  int          n_fail, n_sent, n_checked, n_settings, idle_cycles;
  logic        calm_in, calm_out;

  row_t rows[25] = '{
    '{1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{1'b0, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{1'b0, FP_QNAN,       1'b1, FP_QNAN, 1'b1},
    '{1'b0, 32'h7F80_0001, 1'b1, FP_QNAN, 1'b1},
    '{1'b0, 32'hFFFF_FFFF, 1'b1, FP_QNAN, 1'b1},
    '{1'b0, FP_PINF,       1'b1, FP_QNAN, 1'b1},
    '{1'b0, FP_NINF,       1'b1, FP_QNAN, 1'b1},
    '{1'b1, FP_PINF,       1'b1, FP_QNAN, 1'b1},
    '{1'b1, FP_QNAN,       1'b1, FP_QNAN, 1'b1},
    '{1'b0, FP_MAXF,       1'b1, FP_QNAN, 1'b1},
    '{1'b0, 32'hFF7F_FFFF, 1'b1, FP_QNAN, 1'b1},
    '{1'b1, FP_MAXF,       1'b1, FP_QNAN, 1'b1},
    '{1'b1, 32'hBFC9_0FDB, 1'b1, 32'h0000_0000, 1'b0},
    '{1'b0, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
    '{1'b0, 32'h8000_0001, 1'b0, 32'h0, 1'b0},
    '{1'b0, 32'h007F_FFFF, 1'b0, 32'h0, 1'b0},
    '{1'b0, 32'h0080_0000, 1'b0, 32'h0, 1'b0},
    '{1'b0, FP_PI,         1'b0, 32'h0, 1'b0},
    '{1'b0, 32'hC049_0FDB, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{1'b0, FP_ONE,        1'b0, 32'h0, 1'b0},
    '{1'b1, FP_NEG_ONE,    1'b0, 32'h0, 1'b0},
    '{1'b0, 32'h4FC9_0FDA, 1'b0, 32'h0, 1'b0},
    '{1'b0, 32'h4FC9_0FDB, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h4FC9_0FDC, 1'b0, 32'h0, 1'b0}
  };

  // ---------------- single-precision arithmetic, round to nearest even
  function automatic logic is_nan32(input logic [31:0] x);
    return (&x[30:23]) && (|x[22:0]);
  endfunction

  function automatic logic is_inf32(input logic [31:0] x);
    return (&x[30:23]) && !(|x[22:0]);
  endfunction

  function automatic logic is_zero32(input logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // significand with hidden bit, and weight of its lsb
  function automatic void unpack32(input logic [31:0] x, output logic [23:0] m,
                                   output int e2);
    if (x[30:23] == 8'd0) begin
      m  = {1'b0, x[22:0]};
      e2 = -149;
    end else begin
      m  = {1'b1, x[22:0]};
      e2 = int'(x[30:23]) - 150;
    end
  endfunction

  // value = sig * 2^e2, rounded to a single
  function automatic logic [31:0] round32(input logic s, input int e2,
                                          input logic [127:0] sig);
    int           p, sh, be;
    logic [127:0] kept, rem, halfv;
    if (sig == 0) return {s, 31'd0};
    p = 127;
    while (!sig[p]) p--;
    be = p + e2 + 127;
    if (be >= 1) sh = p - 23;
    else begin
      sh = -149 - e2;
      be = 0;
    end
    if (sh <= 0) kept = sig << (-sh);
    else if (sh > 126) kept = 0;
    else begin
      kept  = sig >> sh;
      rem   = sig & ((128'd1 << sh) - 1);
      halfv = 128'd1 << (sh - 1);
      if (rem > halfv || (rem == halfv && kept[0])) kept = kept + 1;
    end
    if (kept[24]) begin
      kept = kept >> 1;
      be++;
    end
    if (be == 0 && kept[23]) be = 1;
    if (be >= 255) return {s, 8'hFF, 23'd0};
    return {s, be[7:0], kept[22:0]};
  endfunction

  function automatic logic [31:0] fmul32(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [23:0] ma, mb;
    int          ea, eb;
    s = a[31] ^ b[31];
    if (is_nan32(a) || is_nan32(b)) return FP_QNAN;
    if (is_inf32(a) || is_inf32(b)) begin
      if (is_zero32(a) || is_zero32(b)) return FP_QNAN;
      return {s, 8'hFF, 23'd0};
    end
    if (is_zero32(a) || is_zero32(b)) return {s, 31'd0};
    unpack32(a, ma, ea);
    unpack32(b, mb, eb);
    return round32(s, ea + eb, 128'(ma) * 128'(mb));
  endfunction

  function automatic logic [31:0] fadd32(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]  hi, lo;
    logic [23:0]  mh, ml;
    int           eh, el, d, ec;
    logic [127:0] xh, xl;
    if (is_nan32(a) || is_nan32(b)) return FP_QNAN;
    if (is_inf32(a) && is_inf32(b) && a[31] != b[31]) return FP_QNAN;
    if (is_inf32(a)) return a;
    if (is_inf32(b)) return b;
    if (is_zero32(a) && is_zero32(b)) return {a[31] & b[31], 31'd0};
    if (is_zero32(a)) return b;
    if (is_zero32(b)) return a;
    if (a[30:23] >= b[30:23]) begin
      hi = a;
      lo = b;
    end else begin
      hi = b;
      lo = a;
    end
    unpack32(hi, mh, eh);
    unpack32(lo, ml, el);
    d = eh - el;
    // far below the rounding point the small operand only acts as sticky
    if (d > 50) begin
      xh = 128'(mh) << 3;
      xl = 128'd1;
      ec = eh - 3;
    end else begin
      xh = 128'(mh) << d;
      xl = 128'(ml);
      ec = el;
    end
    if (hi[31] == lo[31]) return round32(hi[31], ec, xh + xl);
    if (xh > xl) return round32(hi[31], ec, xh - xl);
    if (xl > xh) return round32(lo[31], ec, xl - xh);
    return 32'h0000_0000;
  endfunction

  function automatic logic [31:0] fsub32(input logic [31:0] a, input logic [31:0] b);
    return fadd32(a, {~b[31], b[30:0]});
  endfunction

  // truncation toward zero of a non-negative single
  function automatic logic [31:0] ftrunc32(input logic [31:0] x);
    int sh;
    if (x[30:23] < 8'd127) return 32'h0000_0000;
    if (x[30:23] >= 8'd150) return x;
    sh = 150 - int'(x[30:23]);
    return x & ~((32'd1 << sh) - 1);
  endfunction

  // ---------------- sine/cosine predictor
  function automatic trig_res_t predict_trig(input logic req, input logic [31:0] ang);
    logic [31:0] a, mag, sgn, tf, turns, halfv, parity, red, sq, poly;
    trig_res_t   r;
    a = req ? fadd32(ang, FP_PI_HALF) : ang;
    r.rbits = FP_QNAN;
    r.rerr  = 1'b1;
    if (&a[30:23]) return r;
    mag = {1'b0, a[30:0]};
    sgn = (a[31] && !is_zero32(a)) ? FP_NEG_ONE : FP_ONE;
    tf  = fadd32(fmul32(mag, FP_INV_PI), FP_HALF);
    if (tf[30:0] >= FP_TURN_LIM[30:0]) return r;
    turns  = ftrunc32(tf);
    halfv  = fmul32(turns, FP_HALF);
    parity = fsub32(ftrunc32(halfv), halfv);
    red    = fsub32(mag, fmul32(turns, FP_PI));
    sq     = fmul32(red, red);
    poly   = fadd32(fmul32(coef_n, sq), coef_s);
    poly   = fadd32(fmul32(poly, sq), coef_q);
    poly   = fadd32(fmul32(poly, sq), coef_c);
    poly   = fmul32(poly, sq);
    sgn    = fadd32(fmul32(fmul32(parity, sgn), FP_FOUR), sgn);
    r.rbits = fmul32(fadd32(fmul32(red, poly), red), sgn);
    r.rerr  = 1'b0;
    return r;
  endfunction

  // ---------------- clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------- result side: random stall per transaction
  initial begin
    int n;
    out_stall_i = 1'b0;
    calm_out    = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 59) == 0) calm_out = ~calm_out;
      n = calm_out ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // ---------------- result check and watchdog
  always @(posedge clk_i) begin
    trig_res_t e;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else if (idle_cycles >= WDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        n_checked++;
        if (trig_q.size() == 0) begin
          $error("result 0x%08h with no transaction outstanding", result_bits_o);
          n_fail++;
        end else begin
          e = trig_q.pop_front();
          if (range_error_o !== e.rerr) begin
            $error("range_error: expected %0b, got %0b", e.rerr, range_error_o);
            n_fail++;
          end
          // NaN payloads from NaN coefficients are not pinned down
          if (!e.rerr && is_nan32(e.rbits)) begin
            if (!is_nan32(result_bits_o)) begin
              $error("result_bits: expected NaN 0x%08h, got 0x%08h", e.rbits,
                     result_bits_o);
              n_fail++;
            end
          end else if (result_bits_o !== e.rbits) begin
            $error("result_bits: expected 0x%08h, got 0x%08h", e.rbits, result_bits_o);
            n_fail++;
          end
        end
      end
    end
  end

  // ---------------- stimulus helpers
  task automatic send_angle(input logic req, input logic [31:0] ang, input logic typed,
                            input trig_res_t typed_res);
    int gap;
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    angle_bits_i <= ang;
    do @(posedge clk_i); while (in_stall_o);
    trig_q.push_back(typed ? typed_res : predict_trig(req, ang));
    n_sent++;
    if ($urandom_range(0, 59) == 0) calm_in = ~calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold the sender until every outstanding result has come back
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (trig_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_coef(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // read back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== val) begin
      $error("prdata: expected 0x%08h, got 0x%08h", val, prdata);
      n_fail++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CUBIC:   coef_c = val;
      REG_QUINTIC: coef_q = val;
      REG_SEPTIC:  coef_s = val;
      default:     coef_n = val;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_angle();
    logic [31:0] b;
    case ($urandom_range(0, 9))
      6: b = $urandom;
      7: b = {1'($urandom), 8'($urandom_range(150, 160)), 23'($urandom)};
      8: case ($urandom_range(0, 2))
           0: b = {1'($urandom), 31'd0};
           1: b = {1'($urandom), 8'd0, 23'($urandom)};
           default: b = {1'($urandom), 8'hFF, 23'($urandom_range(0, 3)) << 21
                         | 23'($urandom_range(0, 1))};
         endcase
      // close to multiples of pi/2, where the reduction is delicate
      9: begin
        b = ($urandom_range(0, 1) ? FP_PI : FP_PI_HALF)
            + (32'($urandom_range(0, 6)) << 23);
        b = b + 32'($urandom_range(0, 8)) - 32'd4;
        b[31] = 1'($urandom);
      end
      default: b = {1'($urandom), 8'($urandom_range(100, 132)), 23'($urandom)};
    endcase
    return b;
  endfunction

  // ---------------- main sequence
  initial begin
    logic [31:0] cset[4];
    trig_res_t   tr;
    n_fail      = 0;
    n_sent      = 0;
    n_checked   = 0;
    n_settings  = 1;
    idle_cycles = 0;
    calm_in     = 1'b0;
    coef_c      = COEF_CUBIC_RST;
    coef_q      = COEF_QUINTIC_RST;
    coef_s      = COEF_SEPTIC_RST;
    coef_n      = COEF_NONIC_RST;
    in_valid_i   = 1'b0;
    req_type_i   = 1'b0;
    angle_bits_i = 32'd0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = 4'd0;
    pwdata       = 32'd0;
    // clean falling edge on the reset before the first clock edge
    #1 rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under reset coefficients
    foreach (rows[i]) begin
      tr.rbits = rows[i].rbits;
      tr.rerr  = rows[i].rerr;
      send_angle(rows[i].req, rows[i].ang, rows[i].typed, tr);
    end

    // random phases, each under its own coefficient setting
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        case (ph)
          1: cset = '{$urandom, $urandom, $urandom, $urandom};
          2: cset = '{32'h0000_0000, 32'hFFFF_FFFF, FP_PINF, 32'h8000_0001};
          3: cset = '{FP_MAXF, 32'hFF7F_FFFF, 32'h0080_0000, 32'h0000_0001};
          4: cset = '{COEF_CUBIC_RST ^ 32'($urandom_range(0, 32'hFFFF)),
                      COEF_QUINTIC_RST ^ 32'($urandom_range(0, 32'hFFFF)),
                      COEF_SEPTIC_RST ^ 32'($urandom_range(0, 32'hFFFF)),
                      COEF_NONIC_RST ^ 32'($urandom_range(0, 32'hFFFF))};
          default: cset = '{COEF_CUBIC_RST, COEF_QUINTIC_RST, COEF_SEPTIC_RST,
                            COEF_NONIC_RST};
        endcase
        drain_pipe();
        write_coef(REG_CUBIC, cset[0]);
        write_coef(REG_QUINTIC, cset[1]);
        write_coef(REG_SEPTIC, cset[2]);
        write_coef(REG_NONIC, cset[3]);
        n_settings++;
        @(posedge clk_i);
      end
      for (int k = 0; k < RAND_ITEMS; k++)
        send_angle(1'($urandom), pick_angle(), 1'b0, tr);
    end

    drain_pipe();
    $display("%0d angles sent and %0d results checked under %0d coefficient settings,",
             n_sent, n_checked, n_settings);
    $display("covering specials, the turn limit, subnormals and random stalls");
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
